// File: design/paenv_pkg.sv
// Shared types, codes and constants for the polyphonic ADSR envelope unit.
package paenv_pkg;

    localparam int unsigned NUM_VOICES_DEF = 16;

    localparam logic [15:0] FULL_SCALE     = 16'h8000;
    localparam logic [15:0] DONE_THRESHOLD = 16'd3;

    localparam int unsigned MAC_A_W = 31;
    localparam int unsigned MAC_B_W = 16;
    localparam int unsigned MAC_C_W = 30;
    localparam int unsigned MAC_P_W = 47;

    typedef enum logic [1:0] {
        REQ_GATE   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_CTRL   = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CFG_ATTACK_COEF   = 3'd0,
        CFG_DECAY_COEF    = 3'd1,
        CFG_SUSTAIN_LEVEL = 3'd2,
        CFG_RELEASE_COEF  = 3'd3,
        CFG_END_VOICE_EN  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         voice;
        logic [15:0]        gate_level;
        logic [15:0]        velocity_mod;
        logic signed [15:0] audio_in;
    } paenv_in_t;

    typedef struct packed {
        logic [3:0]         out_voice;
        logic signed [15:0] audio_out;
        logic [2:0]         phase_now;
        logic               voice_ended;
    } paenv_out_t;

    typedef struct packed {
        logic [15:0] level;
        phase_t      phase;
        logic [15:0] velocity;
    } paenv_entry_t;

    function automatic logic [15:0] sat_q15(input logic [15:0] x);
        return (x > FULL_SCALE) ? FULL_SCALE : x;
    endfunction

endpackage

// File: design/paenv_mac.sv
// Registered multiply-add unit shared by all envelope computations.
module paenv_mac
    import paenv_pkg::*;
(
    input  logic               aclk,
    input  logic [MAC_A_W-1:0] op_a,
    input  logic [MAC_B_W-1:0] op_b,
    input  logic [MAC_C_W-1:0] op_c,
    output logic [MAC_P_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= MAC_P_W'(op_a) * MAC_P_W'(op_b) + MAC_P_W'(op_c);
    end

endmodule

// File: design/poly_adsr_envelope_unit.sv
// Top level of the polyphonic ADSR envelope unit with exponential segments.
// Each voice holds a Q1.15 level, a phase and a velocity in a small memory, with
// one valid bit per voice so that reset takes effect at once with no clearing
// pass. Every item is handled by a sequencer around one registered 31x16
// multiply-add unit, and the input is ready only while the sequencer is idle.
// A zero-level gate item ends in the load state; a key-on gate item adds a
// velocity state, a control item a result state, and a sample item two output
// states and a result state, with a level-advance state before them when the
// level moves. A result waits in a result register, and the unit stalls before
// writing it to the output register only while a previous result is untaken.
module poly_adsr_envelope_unit
    import paenv_pkg::*;
#(
    parameter int unsigned NUM_VOICES = NUM_VOICES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  paenv_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output paenv_out_t m_data
);

    localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam logic [8:0] VOICE_MAX = 9'(NUM_VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GVEL,
        S_ADV,
        S_OUT1,
        S_OUT2,
        S_RESULT
    } state_t;

    state_t       state_reg;
    logic [15:0]  attack_coef_reg;
    logic [15:0]  decay_coef_reg;
    logic [15:0]  sustain_level_reg;
    logic [15:0]  release_coef_reg;
    logic         end_voice_en_reg;

    logic [1:0]   req_type_reg;
    logic [3:0]   voice_reg;
    logic [VW-1:0] idx_reg;
    logic [15:0]  gate_reg;
    logic [15:0]  mod_reg;
    logic [15:0]  mag_reg;
    logic         neg_reg;

    paenv_entry_t env_ram [NUM_VOICES];
    logic [NUM_VOICES-1:0] valid_reg;
    paenv_entry_t rd_entry_reg;
    logic         rd_valid_reg;

    paenv_entry_t cur_reg;
    logic         up_reg;
    logic [15:0]  diff_reg;
    paenv_out_t   res_reg;
    logic         m_valid_reg;
    paenv_out_t   m_data_reg;

    logic [8:0]   voice_ext;
    logic [8:0]   voice_clamp;
    logic [VW-1:0] s_idx;

    paenv_entry_t entry_cur;
    logic [15:0]  coef;
    logic [15:0]  target;
    logic         lvl_up;
    logic [15:0]  diff;
    logic         advance;
    logic [15:0]  step_raw;
    logic [15:0]  step;
    logic [15:0]  new_level;
    logic [17:0]  vel_sum;
    logic [15:0]  vel_new;
    phase_t       ctrl_phase;
    logic         ctrl_ended;
    logic [16:0]  p_out;
    logic [15:0]  audio_val;

    logic [MAC_A_W-1:0] mac_a;
    logic [MAC_B_W-1:0] mac_b;
    logic [MAC_C_W-1:0] mac_c;
    logic [MAC_P_W-1:0] mac_p;

    logic         mem_we;
    paenv_entry_t mem_wdata;

    assign voice_ext   = {5'd0, s_data.voice};
    assign voice_clamp = (voice_ext > VOICE_MAX) ? VOICE_MAX : voice_ext;
    assign s_idx       = voice_clamp[VW-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    paenv_mac u_mac (
        .aclk     (aclk),
        .op_a     (mac_a),
        .op_b     (mac_b),
        .op_c     (mac_c),
        .prod_reg (mac_p)
    );

    always_comb begin
        entry_cur = rd_valid_reg ? rd_entry_reg : '0;
        case (entry_cur.phase) inside
            PH_ATTACK: begin
                coef   = attack_coef_reg;
                target = FULL_SCALE;
            end
            PH_DECAY: begin
                coef   = decay_coef_reg;
                target = sustain_level_reg;
            end
            PH_RELEASE, PH_DONE: begin
                coef   = release_coef_reg;
                target = 16'd0;
            end
            default: begin
                coef   = 16'd0;
                target = 16'd0;
            end
        endcase
        lvl_up  = entry_cur.level < target;
        diff    = lvl_up ? (target - entry_cur.level) : (entry_cur.level - target);
        advance = (coef != 16'd0) && (entry_cur.level != target);

        step_raw  = mac_p[31:16];
        step      = (step_raw > diff_reg) ? diff_reg : step_raw;
        new_level = up_reg ? (cur_reg.level + step) : (cur_reg.level - step);

        vel_sum = 18'(mac_p[31:15]) + 18'(FULL_SCALE) - 18'(mod_reg);
        vel_new = (vel_sum > 18'(FULL_SCALE)) ? FULL_SCALE : vel_sum[15:0];

        ctrl_phase = entry_cur.phase;
        ctrl_ended = 1'b0;
        case (entry_cur.phase)
            PH_ATTACK: begin
                if (entry_cur.level >= FULL_SCALE) begin
                    ctrl_phase = PH_DECAY;
                end
            end
            PH_DECAY: begin
                if (entry_cur.level <= sustain_level_reg) begin
                    ctrl_phase = PH_SUSTAIN;
                end
            end
            PH_RELEASE: begin
                if (entry_cur.level <= DONE_THRESHOLD) begin
                    ctrl_phase = PH_DONE;
                    ctrl_ended = end_voice_en_reg;
                end
            end
            default: begin
                ctrl_phase = entry_cur.phase;
            end
        endcase

        p_out = mac_p[46:30];
        if (neg_reg) begin
            audio_val = (p_out > 17'd32768) ? 16'h8000 : 16'(17'd0 - p_out);
        end else begin
            audio_val = (p_out > 17'd32767) ? 16'h7FFF : p_out[15:0];
        end
    end

    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        case (state_reg)
            S_LOAD: begin
                if (req_type_reg == REQ_GATE) begin
                    mac_a = MAC_A_W'(gate_reg);
                    mac_b = mod_reg;
                    mac_c = MAC_C_W'(16384);
                end else if (advance) begin
                    mac_a = MAC_A_W'(diff);
                    mac_b = coef;
                    mac_c = MAC_C_W'(65535);
                end else begin
                    mac_a = MAC_A_W'(mag_reg);
                    mac_b = entry_cur.level;
                end
            end
            S_ADV: begin
                mac_a = MAC_A_W'(mag_reg);
                mac_b = new_level;
            end
            S_OUT1: begin
                mac_a = mac_p[MAC_A_W-1:0];
                mac_b = cur_reg.velocity;
                mac_c = MAC_C_W'(1 << 29);
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = entry_cur;
        case (state_reg)
            S_LOAD: begin
                if (req_type_reg == REQ_GATE && gate_reg == 16'd0) begin
                    mem_we          = 1'b1;
                    mem_wdata.phase = PH_RELEASE;
                end else if (req_type_reg == REQ_CTRL) begin
                    mem_we          = 1'b1;
                    mem_wdata.phase = ctrl_phase;
                end
            end
            S_GVEL: begin
                mem_we             = 1'b1;
                mem_wdata.level    = 16'd0;
                mem_wdata.phase    = PH_ATTACK;
                mem_wdata.velocity = vel_new;
            end
            S_ADV: begin
                mem_we          = 1'b1;
                mem_wdata       = cur_reg;
                mem_wdata.level = new_level;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rd_entry_reg <= env_ram[s_idx];
            rd_valid_reg <= valid_reg[s_idx];
        end
        if (mem_we) begin
            env_ram[idx_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            attack_coef_reg   <= 16'd655;
            decay_coef_reg    <= 16'd328;
            sustain_level_reg <= 16'd16384;
            release_coef_reg  <= 16'd328;
            end_voice_en_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ATTACK_COEF:   attack_coef_reg   <= cfg_wdata;
                    CFG_DECAY_COEF:    decay_coef_reg    <= cfg_wdata;
                    CFG_SUSTAIN_LEVEL: sustain_level_reg <= sat_q15(cfg_wdata);
                    CFG_RELEASE_COEF:  release_coef_reg  <= cfg_wdata;
                    CFG_END_VOICE_EN:  end_voice_en_reg  <= cfg_wdata[0];
                    default:           end_voice_en_reg  <= end_voice_en_reg;
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != S_RESULT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_type_reg <= s_data.req_type;
                        voice_reg    <= voice_clamp[3:0];
                        idx_reg      <= s_idx;
                        gate_reg     <= sat_q15(s_data.gate_level);
                        mod_reg      <= sat_q15(s_data.velocity_mod);
                        neg_reg      <= s_data.audio_in[15];
                        mag_reg      <= s_data.audio_in[15] ? 16'(16'd0 - s_data.audio_in)
                                                            : s_data.audio_in;
                        state_reg    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    cur_reg  <= entry_cur;
                    up_reg   <= lvl_up;
                    diff_reg <= diff;
                    case (req_type_reg)
                        REQ_GATE: begin
                            state_reg <= (gate_reg != 16'd0) ? S_GVEL : S_IDLE;
                        end
                        REQ_SAMPLE: begin
                            state_reg <= advance ? S_ADV : S_OUT1;
                        end
                        REQ_CTRL: begin
                            res_reg.out_voice   <= voice_reg;
                            res_reg.audio_out   <= '0;
                            res_reg.phase_now   <= ctrl_phase;
                            res_reg.voice_ended <= ctrl_ended;
                            state_reg           <= S_RESULT;
                        end
                        default: begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_GVEL: begin
                    state_reg <= S_IDLE;
                end
                S_ADV: begin
                    cur_reg.level <= new_level;
                    state_reg     <= S_OUT1;
                end
                S_OUT1: begin
                    state_reg <= S_OUT2;
                end
                S_OUT2: begin
                    res_reg.out_voice   <= voice_reg;
                    res_reg.audio_out   <= audio_val;
                    res_reg.phase_now   <= cur_reg.phase;
                    res_reg.voice_ended <= 1'b0;
                    state_reg           <= S_RESULT;
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ADV |-> new_level <= FULL_SCALE)
        else $error("envelope level stepped beyond full scale");

    a_end_has_no_audio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.voice_ended |-> m_data.audio_out == 16'sd0)
        else $error("voice end reported with nonzero audio");

    a_phase_code_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.phase_now <= PH_DONE)
        else $error("result carries an undefined phase");

endmodule
